// ----- design/hcbp_pkg.sv -----
// hcbp_pkg: shared types and constants for the prefix-code bit packer
// no dependencies; used by every module of the block
package hcbp_pkg;

    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int SYM_W        = 8;
    localparam int BYTE_BITS    = 8;
    localparam int PEND_BITS    = 7;
    localparam int TOTAL_W      = 6;
    localparam int ACC_W        = CODE_W + PEND_BITS;
    localparam int TABLE_DEPTH  = 256;
    localparam int FIFO_DEPTH   = 4;
    localparam int MAX_CODE_LEN = 32;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } t_func;

    typedef struct packed {
        logic              flush;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_cmd;

endpackage

// ----- design/huffman_code_bit_packer_unit.sv -----
// Prefix-code bit packer: a load request writes one entry of the 256-entry code table,
// an encode request appends that symbol's code to the bit stream, most significant
// code bit first, and a flush request emits the partial byte zero-padded and clears
// it. The intake side takes one request per cycle while the four-entry command queue
// has room; the table needs no clearing pass and an entry must be loaded before it is
// encoded. Zero-length codes are dropped at intake. The packer takes in each encode,
// then emits its bytes one at a time before it takes the next command; emitting a
// byte waits while the output byte is held unpopped. A flush emits its byte in the
// cycle it is taken in. The single output port is one byte wide. While reset is held,
// full and empty both stay high.
// depends on hcbp_pkg, hcbp_front, hcbp_cmd_fifo, hcbp_back
module huffman_code_bit_packer_unit #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     i_func,
    input  logic [hcbp_pkg::SYM_W-1:0]     i_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]    i_code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]     i_code_len,
    output logic                           empty,
    input  logic                           pop,
    output logic [hcbp_pkg::BYTE_BITS-1:0] o_out_byte,
    output logic                           o_last
);

    logic           fe_cmd_valid;
    hcbp_pkg::t_cmd fe_cmd;
    logic           q_full;
    logic           q_valid;
    hcbp_pkg::t_cmd q_cmd;
    logic           q_pop;
    logic           out_valid;

    hcbp_front #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_func      (i_func),
        .i_symbol    (i_symbol),
        .i_code_bits (i_code_bits),
        .i_code_len  (i_code_len),
        .i_fifo_full (q_full),
        .o_full      (full),
        .o_cmd_valid (fe_cmd_valid),
        .o_cmd       (fe_cmd)
    );

    hcbp_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_cmd_valid),
        .i_wr_cmd   (fe_cmd),
        .o_full     (q_full),
        .o_rd_valid (q_valid),
        .o_rd_cmd   (q_cmd),
        .i_rd_pop   (q_pop)
    );

    hcbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_last),
        .i_pop       (pop)
    );

    assign empty = !out_valid || !i_rst_n;

endmodule

// ----- design/hcbp_front.sv -----
// hcbp_front: request intake, code table and lookup stage
// depends on hcbp_pkg; feeds hcbp_cmd_fifo
module hcbp_front #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [1:0]                    i_func,
    input  logic [hcbp_pkg::SYM_W-1:0]    i_symbol,
    input  logic [hcbp_pkg::CODE_W-1:0]   i_code_bits,
    input  logic [hcbp_pkg::LEN_W-1:0]    i_code_len,
    input  logic                          i_fifo_full,
    output logic                          o_full,
    output logic                          o_cmd_valid,
    output hcbp_pkg::t_cmd                o_cmd
);

    localparam int LEN_LIM = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : hcbp_pkg::CODE_W;

    logic [hcbp_pkg::CODE_W-1:0] r_code_mem [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::LEN_W-1:0]  r_len_mem  [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::CODE_W-1:0] r_rd_code;
    logic [hcbp_pkg::LEN_W-1:0]  r_rd_len;
    logic                        r_s1_valid;
    logic                        r_s1_flush;

    logic                        accept;
    logic                        is_load;
    logic                        is_encode;
    logic                        is_flush;
    logic                        s1_advance;
    logic [hcbp_pkg::LEN_W-1:0]  ld_len;

    always_comb begin
        is_load   = (i_func == hcbp_pkg::FUNC_LOAD);
        is_encode = (i_func == hcbp_pkg::FUNC_ENCODE);
        is_flush  = (i_func == hcbp_pkg::FUNC_FLUSH);
        s1_advance = !r_s1_valid || !i_fifo_full;
        o_full     = !s1_advance || !i_rst_n;
        accept     = i_push && !o_full;
        ld_len     = (i_code_len > hcbp_pkg::LEN_W'(LEN_LIM))
                   ? hcbp_pkg::LEN_W'(LEN_LIM) : i_code_len;
        // zero-length codes are dropped here
        o_cmd_valid = r_s1_valid && (r_s1_flush || (r_rd_len != '0));
        o_cmd.flush = r_s1_flush;
        o_cmd.len   = r_rd_len;
        o_cmd.code  = r_rd_code;
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_load) begin
            r_code_mem[i_symbol] <= i_code_bits;
            r_len_mem[i_symbol]  <= ld_len;
        end
        if (accept && is_encode) begin
            r_rd_code <= r_code_mem[i_symbol];
            r_rd_len  <= r_len_mem[i_symbol];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_flush <= 1'b0;
        end else if (s1_advance) begin
            r_s1_valid <= i_push && (is_encode || is_flush);
            r_s1_flush <= is_flush;
        end
    end

endmodule

// ----- design/hcbp_cmd_fifo.sv -----
// hcbp_cmd_fifo: short command queue between intake and packer
// depends on hcbp_pkg
module hcbp_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    input  hcbp_pkg::t_cmd i_wr_cmd,
    output logic           o_full,
    output logic           o_rd_valid,
    output hcbp_pkg::t_cmd o_rd_cmd,
    input  logic           i_rd_pop
);

    localparam int IDX_W = $clog2(hcbp_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(hcbp_pkg::FIFO_DEPTH + 1);

    hcbp_pkg::t_cmd   r_mem [hcbp_pkg::FIFO_DEPTH];
    logic [IDX_W-1:0] r_wr_ptr;
    logic [IDX_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    always_comb begin
        o_full     = (r_count == CNT_W'(hcbp_pkg::FIFO_DEPTH));
        o_rd_valid = (r_count != '0);
        o_rd_cmd   = r_mem[r_rd_ptr];
        do_wr      = i_wr_valid && !o_full;
        do_rd      = i_rd_pop && o_rd_valid;
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + IDX_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + IDX_W'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/hcbp_back.sv -----
// hcbp_back: bit packer, one byte per cycle while the output byte is not held unpopped, with the output register
// depends on hcbp_pkg; reads commands from hcbp_cmd_fifo
module hcbp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  hcbp_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_out_valid,
    output logic [hcbp_pkg::BYTE_BITS-1:0] o_out_byte,
    output logic                          o_out_last,
    input  logic                          i_pop
);

    logic [hcbp_pkg::ACC_W-1:0]     r_acc;
    logic [hcbp_pkg::TOTAL_W-1:0]   r_total;
    logic                           r_out_valid;
    logic [hcbp_pkg::BYTE_BITS-1:0] r_out_byte;
    logic                           r_out_last;

    logic [hcbp_pkg::ACC_W-1:0]     n_acc;
    logic [hcbp_pkg::TOTAL_W-1:0]   n_total;
    logic                           n_out_valid;
    logic [hcbp_pkg::BYTE_BITS-1:0] n_out_byte;
    logic                           n_out_last;

    logic                           out_ready;
    logic [hcbp_pkg::PEND_BITS-1:0] pend;
    logic [hcbp_pkg::CODE_W-1:0]    code_m;

    always_comb begin
        out_ready = !r_out_valid || i_pop;
        pend   = r_acc[hcbp_pkg::PEND_BITS-1:0]
               & ~({hcbp_pkg::PEND_BITS{1'b1}} << r_total[2:0]);
        code_m = i_cmd.code & ~({hcbp_pkg::CODE_W{1'b1}} << i_cmd.len);

        o_cmd_pop   = 1'b0;
        n_acc       = r_acc;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_pop;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (r_total >= hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_BITS)) begin
            if (out_ready) begin
                n_total     = r_total - hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_BITS);
                n_out_valid = 1'b1;
                n_out_byte  = hcbp_pkg::BYTE_BITS'(r_acc >> n_total);
                n_out_last  = (n_total < hcbp_pkg::TOTAL_W'(hcbp_pkg::BYTE_BITS));
            end
        end else if (i_cmd_valid) begin
            if (i_cmd.flush) begin
                if (r_total == '0) begin
                    o_cmd_pop = 1'b1;
                end else if (out_ready) begin
                    o_cmd_pop   = 1'b1;
                    n_total     = '0;
                    n_out_valid = 1'b1;
                    n_out_byte  = hcbp_pkg::BYTE_BITS'({pend, 1'b0}
                                  << (3'(hcbp_pkg::PEND_BITS) - r_total[2:0]));
                    n_out_last  = 1'b1;
                end
            end else begin
                o_cmd_pop = 1'b1;
                n_acc     = (hcbp_pkg::ACC_W'(pend) << i_cmd.len)
                          | hcbp_pkg::ACC_W'(code_m);
                n_total   = r_total + i_cmd.len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc      <= n_acc;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

// ----- design/hcbp_checker.sv -----
// hcbp_checker: port-level assertions for the bit packer, bound to the top level
// depends on hcbp_pkg and huffman_code_bit_packer_unit
module hcbp_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [hcbp_pkg::BYTE_BITS-1:0] o_out_byte,
    input logic                           o_last
);

    // nothing waits on either side right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) $past(!i_rst_n) |-> empty)
        else $error("result waiting right after reset");

    a_room_after_reset: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) $past(!i_rst_n) |-> !full)
        else $error("intake full right after reset");

    // a byte cannot appear right after reset without an accepted request before it
    a_no_early_result: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) ($past(!i_rst_n) && !(push && !full)) |=> empty)
        else $error("result appeared without an earlier request");

    a_result_holds: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) (!empty && !pop) |=>
            (!empty && $stable(o_out_byte) && $stable(o_last)))
        else $error("waiting result changed before pop");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .o_out_byte (o_out_byte),
    .o_last     (o_last)
);
